// File: sv/dpq_pkg.sv
// Package for the distance priority queue: payload types, action and
// status codes, controller command/status structs. No dependencies.
package dpq_pkg;

  localparam int Capacity  = 256;
  localparam int SlotBits  = 8;
  localparam int CountBits = 9;
  localparam int DistBits  = 17;
  localparam int SqBits    = 34;

  localparam logic [2:0] ACT_ENQ    = 3'd0;
  localparam logic [2:0] ACT_DEQ    = 3'd1;
  localparam logic [2:0] ACT_PEEK   = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;
  localparam logic [2:0] ACT_MOVE   = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_DUP   = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } dpq_in_t;

  typedef struct packed {
    logic signed [15:0]   out_x;
    logic signed [15:0]   out_y;
    logic [1:0]           status;
    logic [CountBits-1:0] entry_count;
  } dpq_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;   // capture input item
    logic scan_clear;  // reset scan results, slot counter to 0
    logic rd_issue;    // read RAM at slot counter
    logic scan_eval;   // evaluate registered read data for slot in flight
    logic slot_inc;    // advance slot counter
    logic sqrt_start;  // start distance unit on dist operands
    logic dist_from_in;// distance of input position (else of read entry)
    logic write_new;   // write input position to free slot
    logic write_dist;  // write distance of in-flight slot
    logic rd_best;     // read RAM at best slot
    logic set_ref;     // store reference point
    logic clr_valid;   // drop found / best slot
    logic clr_all;     // drop all entries
    logic cnt_inc;
    logic cnt_dec;
    logic res_out;     // build result with position of best slot
    logic [1:0] res_status;
    logic res_load;
  } dpq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] action;
    logic       slot_last;  // slot counter at last slot
    logic       found;
    logic       have_free;
    logic       have_best;
    logic       cur_valid;  // valid bit of slot counter
    logic       sqrt_done;
  } dpq_stat_t;

endpackage

// File: sv/dpq_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module dpq_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/dpq_isqrt.sv
// Rounded square root of dx*dx+dy*dy, one result bit per cycle.
// Uses dpq_pkg.
module dpq_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [16:0]           dx,
  input  logic signed [16:0]           dy,
  output logic                         done,
  output logic [dpq_pkg::DistBits-1:0] root
);
  import dpq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SQ   = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state;
  logic [16:0]       ax, ay;
  logic [SqBits-1:0] rem;
  logic [SqBits-1:0] res;
  logic [SqBits-1:0] bitv;
  logic [SqBits-1:0] trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ax    <= dx[16] ? 17'(-dx) : 17'(dx);
            ay    <= dy[16] ? 17'(-dy) : 17'(dy);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          // Two 17x17 products, registered.
          rem   <= SqBits'(ax * ax) + SqBits'(ay * ay);
          res   <= '0;
          bitv  <= SqBits'(1) << (SqBits - 2);
          state <= S_RUN;
        end
        S_RUN: begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // rem = s - r*r; round up when it exceeds r.
          root  <= (rem > res) ? DistBits'(res + 1'b1) : DistBits'(res);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/dpq_datapath.sv
// Datapath: entry RAMs, valid bits, scan compare, distance unit, result.
// Uses dpq_pkg, dpq_ram, dpq_isqrt.
module dpq_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dpq_pkg::dpq_in_t    in_item,
  input  logic                far_first,
  input  dpq_pkg::dpq_cmd_t   cmd,
  output dpq_pkg::dpq_stat_t  stat,
  output dpq_pkg::dpq_out_t   result
);
  import dpq_pkg::*;

  dpq_in_t              item;
  logic [Capacity-1:0]  valid;
  logic [CountBits-1:0] count;
  logic signed [15:0]   ref_x, ref_y;
  logic [SlotBits-1:0]  slot;       // scan counter / RAM address
  logic [SlotBits-1:0]  rd_slot;    // slot whose data is on rdata
  logic [SlotBits-1:0]  found_slot, free_slot, best_slot;
  logic                 found, have_free, have_best;
  logic [DistBits-1:0]  best_dist;
  logic [SlotBits-1:0]  addr;
  logic                 we_xy, we_d;
  logic [15:0]          rx, ry;
  logic [DistBits-1:0]  rd, sq_dist, wd;
  logic signed [16:0]   dx, dy;
  logic                 sq_done;
  logic                 better;

  // Write new entry to free slot, distance write to in-flight slot,
  // result read at best slot, else the scan counter.
  assign addr  = cmd.write_new  ? free_slot :
                 cmd.write_dist ? rd_slot   :
                 cmd.rd_best    ? best_slot : slot;
  assign we_xy = cmd.write_new;
  assign we_d  = cmd.write_new | cmd.write_dist;
  assign wd    = sq_dist;

  dpq_ram #(.Width(16), .Depth(Capacity)) u_x (
    .clk(clk), .we(we_xy), .addr(addr), .wdata(item.pos_x), .rdata(rx));
  dpq_ram #(.Width(16), .Depth(Capacity)) u_y (
    .clk(clk), .we(we_xy), .addr(addr), .wdata(item.pos_y), .rdata(ry));
  dpq_ram #(.Width(DistBits), .Depth(Capacity)) u_d (
    .clk(clk), .we(we_d), .addr(addr), .wdata(wd), .rdata(rd));

  always_comb begin
    if (cmd.dist_from_in) begin
      dx = 17'(item.pos_x) - 17'(ref_x);
      dy = 17'(item.pos_y) - 17'(ref_y);
    end else begin
      dx = 17'($signed(rx)) - 17'(ref_x);
      dy = 17'($signed(ry)) - 17'(ref_y);
    end
  end

  dpq_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.sqrt_start),
    .dx(dx), .dy(dy), .done(sq_done), .root(sq_dist));

  assign better = far_first ? (rd > best_dist) : (rd < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      ref_x <= '0;
      ref_y <= '0;
    end else begin
      if (cmd.load_item) begin
        item <= in_item;
      end
      if (cmd.scan_clear) begin
        slot      <= '0;
        found     <= 1'b0;
        have_free <= 1'b0;
        have_best <= 1'b0;
      end
      if (cmd.rd_issue) begin
        rd_slot <= slot;
      end
      if (cmd.slot_inc) begin
        slot <= slot + 1'b1;
      end
      if (cmd.scan_eval) begin
        if (!valid[rd_slot]) begin
          if (!have_free) begin
            have_free <= 1'b1;
            free_slot <= rd_slot;
          end
        end else begin
          if (!found && rx == item.pos_x && ry == item.pos_y) begin
            found      <= 1'b1;
            found_slot <= rd_slot;
          end
          if (!have_best || better) begin
            have_best <= 1'b1;
            best_slot <= rd_slot;
            best_dist <= rd;
          end
        end
      end
      if (cmd.set_ref) begin
        ref_x <= item.pos_x;
        ref_y <= item.pos_y;
      end
      if (cmd.write_new) begin
        valid[free_slot] <= 1'b1;
      end
      if (cmd.clr_valid) begin
        valid[(item.action == ACT_REMOVE) ? found_slot : best_slot] <= 1'b0;
      end
      if (cmd.clr_all) begin
        valid <= '0;
        count <= '0;
      end
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end
      if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
    end
  end

  // Result register; rx/ry hold best entry after the read issued for it.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.out_x       <= cmd.res_out ? $signed(rx) : 16'sd0;
      result.out_y       <= cmd.res_out ? $signed(ry) : 16'sd0;
      result.status      <= cmd.res_status;
      result.entry_count <= count;
    end
  end

  assign stat.action    = item.action;
  assign stat.slot_last = (slot == SlotBits'(Capacity - 1));
  assign stat.found     = found;
  assign stat.have_free = have_free;
  assign stat.have_best = have_best;
  assign stat.cur_valid = valid[slot];
  assign stat.sqrt_done = sq_done;
endmodule

// File: sv/dpq_ctrl.sv
// Controller state machine: sequences scans, distance updates and results.
// Uses dpq_pkg.
module dpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  dpq_pkg::dpq_stat_t stat,
  output dpq_pkg::dpq_cmd_t  cmd
);
  import dpq_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;  // issue reads
  localparam logic [3:0] S_SLAST  = 4'd3;  // evaluate last read
  localparam logic [3:0] S_DEC    = 4'd4;  // decide after scan
  localparam logic [3:0] S_ESQ    = 4'd5;  // enqueue distance running
  localparam logic [3:0] S_BRD    = 4'd6;  // read best slot
  localparam logic [3:0] S_BWT    = 4'd7;
  localparam logic [3:0] S_MRD    = 4'd8;  // move: read slot
  localparam logic [3:0] S_MWT    = 4'd9;
  localparam logic [3:0] S_MSQ    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state, state_next;
  logic       mlast, mlast_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mlast <= 1'b0;
    end else begin
      state <= state_next;
      mlast <= mlast_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    mlast_next = mlast;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item  = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.action)
          ACT_ENQ, ACT_DEQ, ACT_PEEK, ACT_REMOVE: begin
            // Issue the read of slot 0 so the scan evaluates from its first cycle.
            cmd.rd_issue = 1'b1;
            cmd.slot_inc = 1'b1;
            state_next   = S_SCAN;
          end
          ACT_CLEAR: begin
            cmd.clr_all = 1'b1;
            state_next  = S_DEC;
          end
          ACT_MOVE: begin
            cmd.set_ref = 1'b1;
            mlast_next  = 1'b0;
            state_next  = S_MRD;
          end
          default: state_next = S_DEC;
        endcase
      end
      S_SCAN: begin
        // Evaluate the slot read last cycle while issuing the next read.
        cmd.rd_issue  = 1'b1;
        cmd.slot_inc  = 1'b1;
        cmd.scan_eval = 1'b1;
        if (stat.slot_last) begin
          state_next = S_SLAST;
        end
      end
      S_SLAST: begin
        cmd.scan_eval = 1'b1;
        state_next    = S_DEC;
      end
      S_DEC: begin
        cmd.res_load = 1'b1;
        state_next   = S_OUT;
        unique case (stat.action)
          ACT_ENQ: begin
            if (stat.found) begin
              cmd.res_status = ST_DUP;
            end else if (!stat.have_free) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.res_load     = 1'b0;
              cmd.dist_from_in = 1'b1;
              cmd.sqrt_start   = 1'b1;
              state_next       = S_ESQ;
            end
          end
          ACT_DEQ, ACT_PEEK: begin
            if (!stat.have_best) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.res_load = 1'b0;
              state_next   = S_BRD;
            end
          end
          ACT_REMOVE: begin
            if (stat.found) begin
              cmd.res_load = 1'b0;
              cmd.clr_valid = 1'b1;
              cmd.cnt_dec   = 1'b1;
              state_next    = S_BWT;
            end else begin
              cmd.res_status = ST_DUP;
            end
          end
          ACT_CLEAR: begin
            cmd.res_load = 1'b0;
            state_next   = S_BWT;
          end
          default: cmd.res_status = ST_DONE;
        endcase
      end
      S_ESQ: begin
        cmd.dist_from_in = 1'b1;
        if (stat.sqrt_done) begin
          cmd.write_new = 1'b1;
          cmd.cnt_inc   = 1'b1;
          state_next    = S_BWT;
        end
      end
      S_BRD: begin
        // Address best slot through the read port; drop it on a dequeue.
        cmd.rd_best = 1'b1;
        if (stat.action == ACT_DEQ) begin
          cmd.clr_valid = 1'b1;
          cmd.cnt_dec   = 1'b1;
        end
        state_next = S_BWT;
      end
      S_BWT: begin
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_DONE;
        cmd.res_out    = (stat.action == ACT_DEQ) || (stat.action == ACT_PEEK);
        state_next     = S_OUT;
      end
      S_MRD: begin
        cmd.rd_issue = 1'b1;
        mlast_next   = stat.slot_last;
        if (stat.cur_valid) begin
          state_next = S_MWT;
        end else begin
          cmd.slot_inc = 1'b1;
          state_next   = stat.slot_last ? S_DEC : S_MRD;
        end
      end
      S_MWT: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_MSQ;
      end
      S_MSQ: begin
        if (stat.sqrt_done) begin
          cmd.write_dist = 1'b1;
          cmd.slot_inc   = 1'b1;
          state_next     = mlast ? S_DEC : S_MRD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: sv/distance_priority_queue_unit.sv
// Distance priority queue top level: controller plus datapath (dpq_pkg).
// Every action but clear and move scans all 256 slots, one RAM read a
// cycle; enqueue then runs the bit-serial root, and move reads every slot
// and runs the root once per live entry. One item in flight; the next
// input transfer comes at the earliest in the cycle after the result
// transfer. Synchronous reset empties the table.
module distance_priority_queue_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dpq_pkg::dpq_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dpq_pkg::dpq_out_t    out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import dpq_pkg::*;

  dpq_cmd_t  cmd;
  dpq_stat_t stat;
  logic      far_first;

  // Register write is always taken.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      far_first <= 1'b0;
    end else if (cfg_valid) begin
      far_first <= cfg_data;
    end
  end

  dpq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd));

  dpq_datapath u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .far_first(far_first),
    .cmd(cmd), .stat(stat), .result(out_data));

endmodule

// File: tb/sv/tb_distance_priority_queue_unit.sv
`timescale 1ns / 100ps
// Testbench for distance_priority_queue_unit: directed table plus random
// actions, checked against an in-bench model of the table. Uses dpq_pkg.
module tb_distance_priority_queue_unit;
  import dpq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  dpq_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dpq_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  distance_priority_queue_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the table, reference point and serving order.
  logic signed [15:0] tbl_x [Capacity];
  logic signed [15:0] tbl_y [Capacity];
  logic [DistBits-1:0] tbl_dist [Capacity];
  logic tbl_live [Capacity];
  int unsigned live_n;
  logic signed [15:0] org_x, org_y;
  logic serve_far;

  dpq_out_t expected_q [$];
  int unsigned error_count;
  int unsigned sent_n, got_n, full_hits, empty_hits;
  int unsigned idle_cycles;
  int unsigned rx_wait;
  bit hold_rx;     // long receiver hold-off request

  // Exact integer rounded distance.
  function automatic logic [DistBits-1:0] round_dist(logic signed [15:0] x,
                                                     logic signed [15:0] y);
    longint dx, dy, sq, r;
    dx = longint'(x) - longint'(org_x);
    dy = longint'(y) - longint'(org_y);
    sq = dx * dx + dy * dy;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= sq)
        r = r + (longint'(1) << b);
    end
    if (sq - r * r > r) r = r + 1;
    return r[DistBits-1:0];
  endfunction

  function automatic int slot_of(logic signed [15:0] x, logic signed [15:0] y);
    for (int i = 0; i < Capacity; i++)
      if (tbl_live[i] && tbl_x[i] == x && tbl_y[i] == y) return i;
    return -1;
  endfunction

  function automatic int pick_best();
    int b;
    b = -1;
    for (int i = 0; i < Capacity; i++) begin
      if (!tbl_live[i]) continue;
      if (b < 0) b = i;
      else if (serve_far ? tbl_dist[i] > tbl_dist[b] : tbl_dist[i] < tbl_dist[b])
        b = i;
    end
    return b;
  endfunction

  // Advance the shadow table by one action and return its result.
  function automatic dpq_out_t queue_step(dpq_in_t it);
    dpq_out_t r;
    int s;
    r = '0;
    r.status = ST_DONE;
    case (it.action)
      ACT_ENQ: begin
        if (slot_of(it.pos_x, it.pos_y) >= 0) r.status = ST_DUP;
        else begin
          s = -1;
          for (int i = 0; i < Capacity; i++)
            if (!tbl_live[i]) begin s = i; break; end
          if (s < 0) r.status = ST_FULL;
          else begin
            tbl_x[s] = it.pos_x;
            tbl_y[s] = it.pos_y;
            tbl_dist[s] = round_dist(it.pos_x, it.pos_y);
            tbl_live[s] = 1'b1;
            live_n++;
          end
        end
      end
      ACT_DEQ, ACT_PEEK: begin
        s = pick_best();
        if (s < 0) r.status = ST_EMPTY;
        else begin
          r.out_x = tbl_x[s];
          r.out_y = tbl_y[s];
          if (it.action == ACT_DEQ) begin
            tbl_live[s] = 1'b0;
            live_n--;
          end
        end
      end
      ACT_REMOVE: begin
        s = slot_of(it.pos_x, it.pos_y);
        if (s < 0) r.status = ST_DUP;
        else begin
          tbl_live[s] = 1'b0;
          live_n--;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < Capacity; i++) tbl_live[i] = 1'b0;
        live_n = 0;
      end
      ACT_MOVE: begin
        org_x = it.pos_x;
        org_y = it.pos_y;
        for (int i = 0; i < Capacity; i++)
          if (tbl_live[i]) tbl_dist[i] = round_dist(tbl_x[i], tbl_y[i]);
      end
      default: ;
    endcase
    r.entry_count = live_n[CountBits-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, dpq_out_t got, dpq_out_t exp_r);
    error_count++;
    $display("MISMATCH %s at %0t: got x=%0d y=%0d st=%0d n=%0d, exp x=%0d y=%0d st=%0d n=%0d",
             what, $realtime, got.out_x, got.out_y, got.status, got.entry_count,
             exp_r.out_x, exp_r.out_y, exp_r.status, exp_r.entry_count);
  endtask

  // Directed table; chk set where the result is typed in.
  typedef struct {
    logic [2:0] act;
    int x;
    int y;
    bit chk;
    dpq_out_t res;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{ACT_DEQ, 0, 0, 1, '{16'sd0, 16'sd0, ST_EMPTY, 9'd0}},
    '{ACT_PEEK, 0, 0, 1, '{16'sd0, 16'sd0, ST_EMPTY, 9'd0}},
    '{ACT_REMOVE, 5, 5, 1, '{16'sd0, 16'sd0, ST_DUP, 9'd0}},
    '{ACT_ENQ, 32767, 32767, 1, '{16'sd0, 16'sd0, ST_DONE, 9'd1}},
    '{ACT_ENQ, -32768, -32768, 1, '{16'sd0, 16'sd0, ST_DONE, 9'd2}},
    '{ACT_ENQ, 32767, 32767, 1, '{16'sd0, 16'sd0, ST_DUP, 9'd2}},
    '{ACT_ENQ, 3, 4, 0, '0},
    '{ACT_ENQ, -3, -4, 0, '0},
    '{ACT_ENQ, 1, 1, 0, '0},
    '{ACT_PEEK, 0, 0, 0, '0},
    '{ACT_DEQ, 0, 0, 0, '0},
    '{ACT_MOVE, 32767, -32768, 0, '0},
    '{ACT_PEEK, 0, 0, 0, '0},
    '{ACT_REMOVE, 1, 1, 0, '0},
    '{ACT_REMOVE, 1, 1, 0, '0},
    '{3'd6, 100, -100, 0, '0},
    '{3'd7, -1, 1, 0, '0},
    '{ACT_MOVE, -32768, 32767, 0, '0},
    '{ACT_DEQ, 0, 0, 0, '0},
    '{ACT_CLEAR, 0, 0, 1, '{16'sd0, 16'sd0, ST_DONE, 9'd0}},
    '{ACT_DEQ, 0, 0, 1, '{16'sd0, 16'sd0, ST_EMPTY, 9'd0}},
    '{ACT_MOVE, 0, 0, 0, '0}
  };

  // Hand over one item and record the expectation; with no gap the next
  // item follows directly and valid stays high.
  task automatic send_item(dpq_in_t it, bit chk, dpq_out_t typed);
    dpq_out_t pred;
    int gap;
    gap = $urandom_range(11);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pred = queue_step(it);
    if (chk && pred != typed) report_mismatch("table", pred, typed);
    if (pred.status == ST_FULL) full_hits++;
    if (pred.status == ST_EMPTY) empty_hits++;
    expected_q = {expected_q, pred};
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_n++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_order(logic v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    serve_far = v;
  endtask

  // Small coordinate ranges make duplicates and ties common.
  function automatic logic signed [15:0] rnd_coord(int mode);
    if (mode == 0) return 16'($urandom);
    return 16'($signed($urandom_range(6)) - 3);
  endfunction

  task automatic random_phase(int n, int fill_bias);
    dpq_in_t it;
    int m, k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      m = $urandom_range(1);
      if (k < fill_bias) it.action = ACT_ENQ;
      else if (k < 70) it.action = 3'($urandom_range(3) + 1);
      else if (k < 72) it.action = ACT_CLEAR;
      else if (k < 75) it.action = ACT_MOVE;
      else if (k < 77) it.action = 3'($urandom_range(7, 6));
      else it.action = ACT_ENQ;
      it.pos_x = rnd_coord(m);
      it.pos_y = rnd_coord(m);
      send_item(it, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      idle_cycles <= 0;
    end else if (hold_rx) begin
      out_ready <= 1'b0;
    end else if (idle_cycles != 0) begin
      idle_cycles <= idle_cycles - 1;
      out_ready <= (idle_cycles == 1);
    end else if (out_valid && out_ready) begin
      // draw the wait for the next result; hold ready when it is zero
      rx_wait = $urandom_range(11);
      idle_cycles <= rx_wait;
      out_ready <= (rx_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_n++;
      if (expected_q.size() == 0) report_mismatch("unexpected", out_data, '0);
      else if (out_data != expected_q[0]) begin
        report_mismatch("result", out_data, expected_q[0]);
        void'(expected_q.pop_front());
      end else void'(expected_q.pop_front());
    end
  end

  // Watchdog: cycles with no transfer on any channel.
  int unsigned quiet;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 200000) begin
      $display("tb_distance_priority_queue_unit: done, errors");
      $finish;
    end
  end

  // Long receiver hold-off, counted here, while the sender keeps offering items.
  initial begin
    hold_rx = 1'b0;
    wait (sent_n > 60);
    hold_rx = 1'b1;
    repeat (3000) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    dpq_in_t it;
    error_count = 0;
    sent_n = 0;
    got_n = 0;
    full_hits = 0;
    empty_hits = 0;
    live_n = 0;
    org_x = '0;
    org_y = '0;
    serve_far = 1'b0;
    for (int i = 0; i < Capacity; i++) tbl_live[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_order(1'b0);
    foreach (dir_rows[i]) begin
      it.action = dir_rows[i].act;
      it.pos_x = 16'(dir_rows[i].x);
      it.pos_y = 16'(dir_rows[i].y);
      send_item(it, dir_rows[i].chk, dir_rows[i].res);
    end
    drain_all();  // sender pause until all results are in
    write_order(1'b1);
    random_phase(300, 40);
    drain_all();
    // fill the table past capacity so full refusals show up
    write_order(1'b0);
    for (int i = 0; i < Capacity + 4; i++) begin
      it.action = ACT_ENQ;
      it.pos_x = 16'(i * 37 - 4000);
      it.pos_y = 16'($urandom);
      send_item(it, 1'b0, '0);
    end
    random_phase(40, 20);
    drain_all();
    write_order(1'b1);
    random_phase(300, 45);
    it = '0;
    it.action = ACT_CLEAR;
    send_item(it, 1'b0, '0);
    drain_all();
    $display("covered %0d actions, %0d results, %0d full and %0d empty refusals",
             sent_n, got_n, full_hits, empty_hits);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("tb_distance_priority_queue_unit: done, clean");
    end else begin
      $display("tb_distance_priority_queue_unit: done, errors");
    end
    $finish;
  end
endmodule
